// ----- src/leib_pkg.sv -----
// ----------------------------------------------------------------------------
// leib_pkg
// shared types, character codes and defaults of the line editing input buffer
// ----------------------------------------------------------------------------
package leib_pkg;

	localparam int unsigned RING_DEPTH_DEF = 128;

	localparam logic [7:0] CH_NUL  = 8'h00;
	localparam logic [7:0] CH_EOF  = 8'h04;
	localparam logic [7:0] CH_BS   = 8'h08;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_DUMP = 8'h10;
	localparam logic [7:0] CH_KILL = 8'h15;
	localparam logic [7:0] CH_DEL  = 8'h7F;
	localparam logic [7:0] CNT_MAX = 8'hFF;

	localparam logic OP_RX  = 1'b0;
	localparam logic OP_POP = 1'b1;

	typedef struct packed {
		logic       operation;
		logic [7:0] rx_char;
		logic       read_first;
	} leib_in_t;

	typedef struct packed {
		logic       echo_valid;
		logic [7:0] echo_char;
		logic [7:0] erase_count;
		logic       line_ready;
		logic       dump_request;
		logic       read_valid;
		logic [7:0] read_char;
		logic       read_eof;
		logic       read_empty;
	} leib_out_t;

	// controller to datapath
	typedef struct packed {
		logic ld_char;
		logic ld_empty;
		logic rd_start;
		logic rd_finish;
	} leib_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic empty;
	} leib_stat_t;

endpackage

// ----- src/line_editing_input_buffer.sv -----
// ----------------------------------------------------------------------------
// line_editing_input_buffer
// canonical terminal line editor on a byte ring
// ----------------------------------------------------------------------------
// Each transaction on the item channel is either a received character
// (operation 0) or a pop by the reader (operation 1), and yields exactly one
// transaction on the result channel. Characters are edited into the
// uncommitted tail of a ring of RING_DEPTH bytes (a power of two): Ctrl-U
// kills the line, Backspace or DEL erases one character, Ctrl-P raises
// dump_request, a zero byte is ignored, anything else is stored and echoed
// (CR becomes LF) or silently dropped when the ring is full; LF, Ctrl-D or a
// ring that just filled commits the line. A pop delivers one committed byte,
// reports read_empty when none is committed, and reports read_eof on Ctrl-D,
// consuming it only when read_first is set. A received character and a pop
// of an empty ring finish directly from idle; a pop that reads the ring also
// passes the ST_READ state, since the ring is a memory with a registered
// read port. One item is in work at a time; the next item is taken in the
// same cycle that the finished result leaves the output register, and the
// input stalls while that result is stalled. No clearing pass is needed after reset.
module line_editing_input_buffer #(
	parameter int unsigned RING_DEPTH = leib_pkg::RING_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  leib_pkg::leib_in_t  item,
	output logic                result_valid,
	input  logic                result_stall,
	output leib_pkg::leib_out_t result
);
	import leib_pkg::*;

	// command and status between controller and datapath
	leib_cmd_t  cmd;
	leib_stat_t stat;

	// sequencing, handshake and result valid
	leib_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.operation    (item.operation),
		.stat         (stat),
		.cmd          (cmd),
		.result_valid (result_valid),
		.result_stall (result_stall)
	);

	// ring, pointers and result payload
	leib_dpath #(
		.RING_DEPTH (RING_DEPTH)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.stat   (stat),
		.result (result)
	);

	// only one datapath command per cycle
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.ld_char, cmd.ld_empty, cmd.rd_start, cmd.rd_finish}))
		else $error("more than one datapath command");

	// a ring read always completes in the following cycle
	a_read_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_start |=> cmd.rd_finish)
		else $error("ring read not completed");

	// a ring read is only started when a committed byte exists
	a_read_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_start |-> !stat.empty)
		else $error("ring read on empty ring");

	// a pop result reports at most one outcome
	a_pop_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $onehot0({result.read_valid, result.read_eof, result.read_empty}))
		else $error("conflicting pop outcome");

endmodule

// ----- src/leib_dpath.sv -----
// ----------------------------------------------------------------------------
// leib_dpath
// ring store, read/commit/edit pointers and result register
// ----------------------------------------------------------------------------
module leib_dpath #(
	parameter int unsigned RING_DEPTH = leib_pkg::RING_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  leib_pkg::leib_in_t  item,
	input  leib_pkg::leib_cmd_t cmd,
	output leib_pkg::leib_stat_t stat,
	output leib_pkg::leib_out_t result
);
	import leib_pkg::*;

	localparam int unsigned IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int unsigned PTR_W = IDX_W + 1;
	localparam int unsigned EXT_W = (PTR_W > 8) ? PTR_W : 8;
	localparam logic [PTR_W-1:0] DEPTH_P = PTR_W'(RING_DEPTH);

	logic [7:0]       ring_q [RING_DEPTH];
	logic [PTR_W-1:0] rp_q, cp_q, ep_q;
	logic [7:0]       rd_data_q;
	logic             first_q;
	leib_out_t        out_q;

	logic [PTR_W-1:0] ep_nxt, cp_nxt, rp_nxt, ep_inc, kill_n;
	logic [EXT_W-1:0] kill_ext;
	logic [7:0]       cc;
	logic             wr_en;
	leib_out_t        chr_res, pop_res, empty_res;

	assign stat.empty = (rp_q == cp_q);
	assign result     = out_q;

	assign ep_inc   = ep_q + PTR_W'(1);
	assign kill_n   = ep_q - cp_q;
	assign kill_ext = EXT_W'(kill_n);
	assign cc       = (item.rx_char == CH_CR) ? CH_LF : item.rx_char;

	// received character handling
	always_comb begin
		ep_nxt  = ep_q;
		cp_nxt  = cp_q;
		wr_en   = 1'b0;
		chr_res = '0;
		if (item.rx_char == CH_DUMP) begin
			chr_res.dump_request = 1'b1;
		end else if (item.rx_char == CH_KILL) begin
			ep_nxt = cp_q;
			chr_res.erase_count = (kill_ext > EXT_W'(CNT_MAX)) ? CNT_MAX : kill_ext[7:0];
		end else if (item.rx_char == CH_BS || item.rx_char == CH_DEL) begin
			if (ep_q != cp_q) begin
				ep_nxt = ep_q - PTR_W'(1);
				chr_res.erase_count = 8'd1;
			end
		end else if (item.rx_char != CH_NUL && (ep_q - rp_q) < DEPTH_P) begin
			chr_res.echo_valid = 1'b1;
			chr_res.echo_char  = cc;
			wr_en  = 1'b1;
			ep_nxt = ep_inc;
			if (cc == CH_LF || cc == CH_EOF || (ep_inc - rp_q) == DEPTH_P) begin
				cp_nxt = ep_inc;
				chr_res.line_ready = 1'b1;
			end
		end
	end

	// pop completion from the registered ring read
	always_comb begin
		rp_nxt    = rp_q;
		pop_res   = '0;
		empty_res = '0;
		empty_res.read_empty = 1'b1;
		if (rd_data_q == CH_EOF) begin
			pop_res.read_eof = 1'b1;
			if (first_q) begin
				rp_nxt = rp_q + PTR_W'(1);
			end
		end else begin
			pop_res.read_valid = 1'b1;
			pop_res.read_char  = rd_data_q;
			rp_nxt = rp_q + PTR_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q <= '0;
			cp_q <= '0;
			ep_q <= '0;
		end else begin
			if (cmd.ld_char) begin
				ep_q <= ep_nxt;
				cp_q <= cp_nxt;
			end
			if (cmd.rd_finish) begin
				rp_q <= rp_nxt;
			end
		end
	end

	// ring memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.ld_char && wr_en) begin
			ring_q[ep_q[IDX_W-1:0]] <= cc;
		end
		if (cmd.rd_start) begin
			rd_data_q <= ring_q[rp_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_start) begin
			first_q <= item.read_first;
		end
		if (cmd.ld_char) begin
			out_q <= chr_res;
		end else if (cmd.ld_empty) begin
			out_q <= empty_res;
		end else if (cmd.rd_finish) begin
			out_q <= pop_res;
		end
	end

endmodule

// ----- src/leib_ctrl.sv -----
// ----------------------------------------------------------------------------
// leib_ctrl
// handshake and sequencing controller
// ----------------------------------------------------------------------------
module leib_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  logic                 operation,
	input  leib_pkg::leib_stat_t stat,
	output leib_pkg::leib_cmd_t  cmd,
	output logic                 result_valid,
	input  logic                 result_stall
);
	import leib_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;

	assign item_stall   = (state_q == ST_READ) || (out_valid_q && result_stall);
	assign accept       = item_valid && !item_stall;
	assign result_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (operation == OP_RX) begin
						cmd.ld_char = 1'b1;
					end else if (stat.empty) begin
						cmd.ld_empty = 1'b1;
					end else begin
						cmd.rd_start = 1'b1;
					end
				end
			end
			ST_READ: begin
				cmd.rd_finish = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.ld_char || cmd.ld_empty) begin
						out_valid_q <= 1'b1;
					end else if (out_valid_q && !result_stall) begin
						out_valid_q <= 1'b0;
					end
					if (cmd.rd_start) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- test/line_editing_input_buffer_tb.sv -----
// ----------------------------------------------------------------------------
// line_editing_input_buffer_tb
// self-checking bench for the canonical line editor on a byte ring
// ----------------------------------------------------------------------------
// Items go in on a valid/stall channel and every accepted item is run
// through a local model of the editor: three pointers over a copy of the
// ring. The model's expected result is queued, and a checker process
// compares each accepted result with the oldest queued one, field by field.
// The stimulus starts with directed cases: empty-line erases, zero byte,
// Ctrl-P, CR to LF, Ctrl-D typed and read, and pops of an empty ring. It then
// kills a longest line, fills the ring until bytes drop, and backs up the
// result side for a long stretch. The bulk is random traffic of typed lines
// with edits, read bursts and raw noise. The sender idles in bursts, the
// receiver stalls on its own pattern, and a watchdog ends a hung run.
// ----------------------------------------------------------------------------
module line_editing_input_buffer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import leib_pkg::*;

	localparam int unsigned RING_DEPTH   = RING_DEPTH_DEF;
	localparam int unsigned PW           = $clog2(2 * RING_DEPTH);
	localparam int unsigned RANDOM_ITEMS = 1400;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned IDLE_LIMIT   = 5000;
	localparam int unsigned TAIL_CYCLES  = 20;
	localparam int unsigned REPORT_MAX   = 100;
	localparam logic [7:0]  PRINT_LO     = 8'h20;
	localparam logic [7:0]  PRINT_HI     = 8'h7E;

	typedef logic [PW-1:0] ptr_t;

	localparam ptr_t DEPTH_P = ptr_t'(RING_DEPTH);

	logic      clk          = 1'b0;
	logic      arst_n       = 1'b0;
	logic      item_valid   = 1'b0;
	logic      item_stall;
	leib_in_t  item         = '0;
	logic      result_valid;
	logic      result_stall = 1'b0;
	leib_out_t result;

	// model state: ring copy and the read, commit and edit pointers
	logic [7:0] ring_copy [RING_DEPTH];
	ptr_t       rd_ptr;
	ptr_t       cm_ptr;
	ptr_t       ed_ptr;

	leib_out_t   line_results_due [$];
	int unsigned items_sent   = 0;
	int unsigned mismatches   = 0;
	int unsigned idle_cycles  = 0;

	// sender burst shaping
	int unsigned burst_left   = 0;
	bit          sender_gaps  = 1'b1;

	// receiver stall pattern and long hold-off
	logic [15:0] stall_bits   = '0;
	logic [3:0]  stall_phase  = '0;
	logic        hold_req     = 1'b0;
	int unsigned hold_left    = 0;

	line_editing_input_buffer #(
		.RING_DEPTH(RING_DEPTH)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// model of the editor
	// ------------------------------------------------------------------------

	// bytes between edit and read pointer, modulo twice the depth
	function automatic ptr_t ring_fill();
		ptr_t d;
		d = ed_ptr - rd_ptr;
		return d;
	endfunction

	function automatic leib_out_t edit_and_read(leib_in_t it);
		leib_out_t  r;
		logic [7:0] c;
		logic [7:0] b;
		ptr_t       n;
		r = '0;
		c = it.rx_char;
		if (it.operation == OP_RX) begin
			if (c == CH_DUMP) begin
				r.dump_request = 1'b1;
			end else if (c == CH_KILL) begin
				// uncommitted part never holds a LF, so the count is just the span
				n = ed_ptr - cm_ptr;
				ed_ptr = cm_ptr;
				r.erase_count = (n > CNT_MAX) ? CNT_MAX : 8'(n);
			end else if (c == CH_BS || c == CH_DEL) begin
				if (ed_ptr != cm_ptr) begin
					ed_ptr = ed_ptr - ptr_t'(1);
					r.erase_count = 8'd1;
				end
			end else if (c != CH_NUL && ring_fill() < DEPTH_P) begin
				if (c == CH_CR) begin
					c = CH_LF;
				end
				r.echo_valid = 1'b1;
				r.echo_char = c;
				ring_copy[ed_ptr[PW-2:0]] = c;
				ed_ptr = ed_ptr + ptr_t'(1);
				// LF, Ctrl-D or a ring that just filled commits the line
				if (c == CH_LF || c == CH_EOF || ring_fill() == DEPTH_P) begin
					cm_ptr = ed_ptr;
					r.line_ready = 1'b1;
				end
			end
		end else begin
			if (rd_ptr == cm_ptr) begin
				r.read_empty = 1'b1;
			end else begin
				b = ring_copy[rd_ptr[PW-2:0]];
				if (b == CH_EOF) begin
					// Ctrl-D is consumed only as the first byte of a read
					r.read_eof = 1'b1;
					if (it.read_first) begin
						rd_ptr = rd_ptr + ptr_t'(1);
					end
				end else begin
					r.read_valid = 1'b1;
					r.read_char = b;
					rd_ptr = rd_ptr + ptr_t'(1);
				end
			end
		end
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// item builders
	// ------------------------------------------------------------------------

	function automatic leib_in_t rx_item(logic [7:0] c);
		leib_in_t it;
		it.operation = OP_RX;
		it.rx_char = c;
		it.read_first = 1'($urandom);
		return it;
	endfunction

	function automatic leib_in_t pop_item(logic first);
		leib_in_t it;
		it.operation = OP_POP;
		it.rx_char = 8'($urandom);
		it.read_first = first;
		return it;
	endfunction

	// mostly printable text with a sprinkling of edit and control codes
	function automatic logic [7:0] pick_line_char();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return 8'($urandom_range(PRINT_LO, PRINT_HI));
		else if (r < 83)
			return CH_BS;
		else if (r < 86)
			return CH_DEL;
		else if (r < 88)
			return CH_KILL;
		else if (r < 90)
			return CH_DUMP;
		else if (r < 92)
			return CH_NUL;
		else
			return 8'($urandom_range(0, 255));
	endfunction

	// ------------------------------------------------------------------------
	// sender
	// ------------------------------------------------------------------------

	// offers one item, waits for the transaction and queues its expected result
	task automatic send_item(leib_in_t it);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 32);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (sender_gaps && gap != 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_stall);
		line_results_due.push_back(edit_and_read(it));
		items_sent++;
	endtask

	// sender goes quiet until every queued result has been seen
	task automatic wait_drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (line_results_due.size() != 0) @(posedge clk);
	endtask

	// pops until nothing committed is left; read_first set so Ctrl-D goes too
	task automatic read_all();
		while (cm_ptr != rd_ptr) send_item(pop_item(1'b1));
	endtask

	task automatic type_chars(int unsigned count);
		repeat (count) send_item(rx_item(8'($urandom_range(PRINT_LO, PRINT_HI))));
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	task automatic test_directed_cases();
		leib_in_t it;
		send_item(pop_item(1'b1));         // empty ring on pop
		send_item(rx_item(CH_NUL));        // zero byte ignored
		send_item(rx_item(CH_DUMP));       // dump request
		send_item(rx_item(CH_BS));         // erases with an empty line
		send_item(rx_item(CH_DEL));
		send_item(rx_item(CH_KILL));
		send_item(rx_item(8'h61));
		send_item(rx_item(8'hFF));         // top code is plain data
		send_item(rx_item(CH_BS));
		send_item(rx_item(8'h01));
		send_item(rx_item(8'h62));
		send_item(rx_item(CH_KILL));       // kills three characters
		send_item(rx_item(8'h78));
		send_item(pop_item(1'b1));         // nothing committed yet
		send_item(rx_item(CH_CR));         // CR becomes LF and commits
		send_item(rx_item(CH_DEL));        // committed bytes cannot be erased
		send_item(pop_item(1'b1));
		send_item(pop_item(1'b0));
		send_item(rx_item(8'hFF));
		send_item(rx_item(CH_EOF));        // Ctrl-D typed is stored and commits
		send_item(pop_item(1'b1));
		send_item(pop_item(1'b0));         // Ctrl-D not first stays in the ring
		send_item(pop_item(1'b0));
		send_item(pop_item(1'b1));         // Ctrl-D first is consumed
		it.operation = OP_POP;
		it.rx_char = 8'hFF;
		it.read_first = 1'b0;
		send_item(it);
		wait_drain();
	endtask

	// longest possible uncommitted line, then a partial kill
	task automatic test_long_kill();
		read_all();
		send_item(rx_item(CH_KILL));
		type_chars(RING_DEPTH - 1);
		send_item(rx_item(CH_KILL));
		type_chars(50);
		repeat (3) send_item(rx_item(CH_BS));
		send_item(rx_item(CH_KILL));
		send_item(rx_item(CH_KILL));
		wait_drain();
	endtask

	// fill the ring until it commits by itself and further bytes drop
	task automatic test_full_ring();
		read_all();
		send_item(rx_item(CH_KILL));
		type_chars(RING_DEPTH + 2);
		send_item(rx_item(CH_BS));
		send_item(rx_item(CH_EOF));
		send_item(rx_item(CH_LF));
		send_item(pop_item(1'b1));
		type_chars(2);
		read_all();
		send_item(pop_item(1'b1));
		wait_drain();
	endtask

	// result side held off while the sender keeps offering back to back
	task automatic test_backpressure();
		sender_gaps = 1'b0;
		hold_req <= 1'b1;
		repeat (40) send_item(rx_item(pick_line_char()));
		send_item(rx_item(CH_LF));
		repeat (20) send_item(pop_item(1'($urandom)));
		wait_drain();
		sender_gaps = 1'b1;
	endtask

	// typed lines with edits, read bursts and raw noise
	task automatic test_random_traffic();
		int unsigned start;
		int unsigned kind;
		int unsigned len;
		leib_in_t    it;
		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) begin
			kind = $urandom_range(0, 99);
			if (kind < 45) begin
				len = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 140)
				                                   : $urandom_range(0, 16);
				repeat (len) send_item(rx_item(pick_line_char()));
				case ($urandom_range(0, 3))
					0: send_item(rx_item(CH_LF));
					1: send_item(rx_item(CH_CR));
					2: send_item(rx_item(CH_EOF));
					default: ;  // line left open, keeps growing
				endcase
			end else if (kind < 85) begin
				// a read: first pop starts it, the rest continue it
				len = $urandom_range(1, 24);
				send_item(pop_item(1'b1));
				repeat (len - 1) send_item(pop_item(($urandom_range(0, 7) == 0)));
			end else if (kind < 97) begin
				it = leib_in_t'($bits(leib_in_t)'($urandom));
				send_item(it);
			end else begin
				// occasional full stop of the sender
				wait_drain();
			end
		end
		wait_drain();
	endtask

	// ------------------------------------------------------------------------
	// receiver stall pattern, with a long hold-off on request
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req <= 1'b0;
		end
		if (hold_left != 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= stall_bits[stall_phase];
			if (stall_phase == 4'hF) begin
				// new pattern each wrap: none, sparse, even or dense stalls
				case ($urandom_range(0, 3))
					0: stall_bits <= '0;
					1: stall_bits <= 16'($urandom & $urandom);
					2: stall_bits <= 16'($urandom);
					default: stall_bits <= 16'($urandom | $urandom);
				endcase
			end
			stall_phase <= stall_phase + 4'd1;
		end
	end

	// ------------------------------------------------------------------------
	// result checker
	// ------------------------------------------------------------------------

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			mismatches++;
			// keep the log readable when something is badly off
			if (mismatches <= REPORT_MAX)
				$error("%s: expected %0h, got %0h", name, want, got);
		end
	endfunction

	always @(posedge clk) begin : result_check
		leib_out_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (line_results_due.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$error("result transaction with nothing expected");
			end else begin
				want = line_results_due.pop_front();
				check_field("echo_valid", 8'(want.echo_valid), 8'(result.echo_valid));
				check_field("echo_char", want.echo_char, result.echo_char);
				check_field("erase_count", want.erase_count, result.erase_count);
				check_field("line_ready", 8'(want.line_ready), 8'(result.line_ready));
				check_field("dump_request", 8'(want.dump_request),
				            8'(result.dump_request));
				check_field("read_valid", 8'(want.read_valid), 8'(result.read_valid));
				check_field("read_char", want.read_char, result.read_char);
				check_field("read_eof", 8'(want.read_eof), 8'(result.read_eof));
				check_field("read_empty", 8'(want.read_empty), 8'(result.read_empty));
			end
		end
	end

	// ------------------------------------------------------------------------
	// watchdog: too long without any transaction on either side
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("line_editing_input_buffer: mismatch");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------------
	initial begin
		rd_ptr = '0;
		cm_ptr = '0;
		ed_ptr = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_long_kill();
		test_full_ring();
		test_backpressure();
		test_random_traffic();

		// any late or extra result shows up as a failure here
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("line_editing_input_buffer: match");
		else
			$display("line_editing_input_buffer: mismatch");
		$finish;
	end

endmodule
